// ===== sv/cpi_pkg.sv =====
// cpi_pkg: shared constants for the circle pair intersection block.
// No dependencies; imported by the multiplier, divider cell and top level.
package cpi_pkg;

  localparam int DIGIT_W = 16;
  localparam int LANES   = 4;

  localparam int LANE_FX = 0;
  localparam int LANE_FY = 1;
  localparam int LANE_SX = 2;
  localparam int LANE_SY = 3;

endpackage

// ===== sv/cpi_circle_if.sv =====
// cpi_circle_if: valid/ready channel carrying one pair of circles per item.
// Stand-alone; width follows the coordinate width of the top level.
interface cpi_circle_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] center_a_x;
  logic signed [CW-1:0] center_a_y;
  logic        [CW-2:0] radius_a;
  logic signed [CW-1:0] center_b_x;
  logic signed [CW-1:0] center_b_y;
  logic        [CW-2:0] radius_b;

  modport source (output valid, center_a_x, center_a_y, radius_a,
                  center_b_x, center_b_y, radius_b, input ready);
  modport sink (input valid, center_a_x, center_a_y, radius_a,
                center_b_x, center_b_y, radius_b, output ready);
endinterface

// ===== sv/cpi_point_if.sv =====
// cpi_point_if: valid/ready channel carrying one pair of crossing points per item.
// Stand-alone; width follows the coordinate width of the top level.
interface cpi_point_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic                 found;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;

  modport source (output valid, found, first_x, first_y, second_x, second_y,
                  input ready);
  modport sink (input valid, found, first_x, first_y, second_x, second_y,
                output ready);
endinterface

// ===== sv/cpi_mul.sv =====
// cpi_mul: pipelined unsigned multiplier, one DIGIT_W-bit digit of b per stage.
// Depends on cpi_pkg.
module cpi_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  import cpi_pkg::*;

  localparam int NS   = (BW + DIGIT_W - 1) / DIGIT_W;
  localparam int BPW  = NS * DIGIT_W;
  localparam int ACCW = AW + BPW;

  logic [AW-1:0]   a_pipe [NS];
  logic [BPW-1:0]  b_pipe [NS];
  logic [ACCW-1:0] acc    [NS];

  assign a_pipe[0] = a;
  assign b_pipe[0] = BPW'(b);

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [AW+DIGIT_W-1:0] part;
    logic [ACCW-1:0]       prev;

    assign part = a_pipe[s] * b_pipe[s][s*DIGIT_W +: DIGIT_W];

    if (s == 0) begin : g_first
      assign prev = '0;
    end else begin : g_next
      assign prev = acc[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[s] <= prev + (ACCW'(part) << (s * DIGIT_W));
      end
    end

    if (s < NS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          a_pipe[s+1] <= a_pipe[s];
          b_pipe[s+1] <= b_pipe[s];
        end
      end
    end
  end

  assign p = acc[NS-1][AW+BW-1:0];

endmodule

// ===== sv/cpi_sqrt_cell.sv =====
// cpi_sqrt_cell: one root bit of a restoring integer square root.
// No dependencies; chained RW times in the top level.
module cpi_sqrt_cell #(
  parameter int RW = 8
) (
  input  logic            clk,
  input  logic            en,
  input  logic [RW-1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  input  logic [2*RW-1:0] rad_in,
  output logic [RW-1:0]   rem_out,
  output logic [RW-1:0]   root_out,
  output logic [2*RW-1:0] rad_out
);
  logic [RW+1:0] rem_t;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  assign rem_t = {rem_in, rad_in[2*RW-1 -: 2]};
  assign trial = {root_in, 2'b01};
  assign diff  = rem_t - trial;
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? diff[RW-1:0] : rem_t[RW-1:0];
      root_out <= {root_in[RW-2:0], ge};
      rad_out  <= {rad_in[2*RW-3:0], 2'b00};
    end
  end

endmodule

// ===== sv/cpi_div_cell.sv =====
// cpi_div_cell: one quotient bit of a restoring division, all lanes sharing a divisor.
// Depends on cpi_pkg; chained QW times in the top level.
module cpi_div_cell #(
  parameter int DNW = 8,
  parameter int QW  = 8
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [DNW-1:0]                      den_in,
  input  logic [cpi_pkg::LANES-1:0][DNW-1:0]  rem_in,
  input  logic [cpi_pkg::LANES-1:0][QW-1:0]   nq_in,
  output logic [DNW-1:0]                      den_out,
  output logic [cpi_pkg::LANES-1:0][DNW-1:0]  rem_out,
  output logic [cpi_pkg::LANES-1:0][QW-1:0]   nq_out
);
  import cpi_pkg::*;

  logic [LANES-1:0][DNW:0] rem_t;
  logic [LANES-1:0][DNW:0] diff;
  logic [LANES-1:0]        ge;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_t[l] = {rem_in[l], nq_in[l][QW-1]};
      diff[l]  = rem_t[l] - {1'b0, den_in};
      ge[l]    = rem_t[l] >= {1'b0, den_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_out <= den_in;
      for (int l = 0; l < LANES; l++) begin
        rem_out[l] <= ge[l] ? diff[l][DNW-1:0] : rem_t[l][DNW-1:0];
        nq_out[l]  <= {nq_in[l][QW-2:0], ge[l]};
      end
    end
  end

endmodule

// ===== sv/cpi_delay.sv =====
// cpi_delay: enabled shift line that carries side data alongside the datapath.
// No dependencies.
module cpi_delay #(
  parameter int DW = 1,
  parameter int N  = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d,
  output logic [DW-1:0] q
);
  logic [DW-1:0] line [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

// ===== sv/circle_pair_intersection_top.sv =====
// circle_pair_intersection_top: crossing points of two circles, exact integer arithmetic.
// Depends on cpi_pkg, cpi_circle_if, cpi_point_if, cpi_mul, cpi_sqrt_cell,
// cpi_div_cell and cpi_delay.
//
// One pair of circles is accepted every clock while the input is not stalled, and one
// result item leaves for each, in order. The pipeline holds the square-root chain of
// 2*W cells for W = COORD_WIDTH, the divider chain of W+1 cells and the digit-serial
// multiplier stages. The whole datapath moves on one enable; a skid register behind
// the output register keeps the input side free while one result waits, and the input
// stalls only when both hold an item. When the circles do not cross in two distinct
// points, found is low and all coordinates are zero; coordinates out of range saturate.
module circle_pair_intersection_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  cpi_circle_if.sink  circles,
  cpi_point_if.source points
);
  import cpi_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int MW1  = W + 1;
  localparam int L1   = (MW1 + DIGIT_W - 1) / DIGIT_W;
  localparam int L2   = (2 * W + DIGIT_W - 1) / DIGIT_W;
  localparam int SQN  = 2 * W;
  localparam int QW   = W + 1;
  localparam int DNW  = 2 * W + 1;
  localparam int SQW  = 2 * W + 2;
  localparam int KW   = 2 * W + 3;
  localparam int KMW  = 2 * W + 2;
  localparam int PRW  = KMW + MW1;
  localparam int NW   = 3 * W + 5;
  localparam int NMW  = NW - 1;
  localparam int VW   = W + 3;

  localparam int T_R3 = L1 + 2;
  localparam int T_S  = T_R3 + L2 + SQN;
  localparam int T_M3 = T_S + L1;
  localparam int T_R6 = T_M3 + 3;
  localparam int T_Q  = T_R6 + QW;

  logic en;
  logic skid_valid;

  assign en = !skid_valid;
  assign circles.ready = en;

  // input stage: differences and their magnitudes
  logic signed [W:0] ax_e, ay_e, bx_e, by_e;
  logic signed [W:0] dx_p, dx_m, dy_p, dy_m;
  logic [W-1:0]      rs_c, rd_p, rd_m;

  assign ax_e = {circles.center_a_x[W-1], circles.center_a_x};
  assign ay_e = {circles.center_a_y[W-1], circles.center_a_y};
  assign bx_e = {circles.center_b_x[W-1], circles.center_b_x};
  assign by_e = {circles.center_b_y[W-1], circles.center_b_y};
  assign dx_p = bx_e - ax_e;
  assign dx_m = ax_e - bx_e;
  assign dy_p = by_e - ay_e;
  assign dy_m = ay_e - by_e;
  assign rs_c = {1'b0, circles.radius_a} + {1'b0, circles.radius_b};
  assign rd_p = {1'b0, circles.radius_a} - {1'b0, circles.radius_b};
  assign rd_m = {1'b0, circles.radius_b} - {1'b0, circles.radius_a};

  logic                 v1;
  logic signed [W-1:0]  ax1, ay1;
  logic [MW1-1:0]       dxm1, dym1;
  logic                 dxn1, dyn1;
  logic [W-1:0]         rs1;
  logic [W-2:0]         rd1, ra1, rb1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= circles.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1  <= circles.center_a_x;
      ay1  <= circles.center_a_y;
      dxn1 <= dx_p[W];
      dyn1 <= dy_p[W];
      dxm1 <= dx_p[W] ? dx_m : dx_p;
      dym1 <= dy_p[W] ? dy_m : dy_p;
      rs1  <= rs_c;
      rd1  <= rd_p[W-1] ? rd_m[W-2:0] : rd_p[W-2:0];
      ra1  <= circles.radius_a;
      rb1  <= circles.radius_b;
    end
  end

  // squares
  logic [SQW-1:0] sq_dx, sq_dy, sq_rs, sq_rd, sq_ra, sq_rb;

  cpi_mul #(.AW(MW1), .BW(MW1)) u_mul_dx (.clk, .en, .a(dxm1), .b(dxm1), .p(sq_dx));
  cpi_mul #(.AW(MW1), .BW(MW1)) u_mul_dy (.clk, .en, .a(dym1), .b(dym1), .p(sq_dy));
  cpi_mul #(.AW(MW1), .BW(MW1)) u_mul_rs (.clk, .en, .a({1'b0, rs1}), .b({1'b0, rs1}),
                                          .p(sq_rs));
  cpi_mul #(.AW(MW1), .BW(MW1)) u_mul_rd (.clk, .en, .a({2'b00, rd1}), .b({2'b00, rd1}),
                                          .p(sq_rd));
  cpi_mul #(.AW(MW1), .BW(MW1)) u_mul_ra (.clk, .en, .a({2'b00, ra1}), .b({2'b00, ra1}),
                                          .p(sq_ra));
  cpi_mul #(.AW(MW1), .BW(MW1)) u_mul_rb (.clk, .en, .a({2'b00, rb1}), .b({2'b00, rb1}),
                                          .p(sq_rb));

  logic [SQW-1:0] d2, sums2, difs2;
  logic [KW-1:0]  r2pos, r2neg;

  always_ff @(posedge clk) begin
    if (en) begin
      d2    <= sq_dx + sq_dy;
      sums2 <= sq_rs;
      difs2 <= sq_rd;
      r2pos <= KW'(sq_ra) - KW'(sq_rb);
      r2neg <= KW'(sq_rb) - KW'(sq_ra);
    end
  end

  // crossing test, K, sqrt operands, divisor
  logic [KW-1:0]  kp_c, km_c;
  logic [SQW-1:0] t1_c, t2_c;
  logic           found3, kneg3;
  logic [KMW-1:0] kmag3;
  logic [2*W-1:0] t1_3, t2_3;
  logic [DNW-1:0] den3;

  assign kp_c = KW'(d2) + r2pos;
  assign km_c = r2neg - KW'(d2);
  assign t1_c = sums2 - d2;
  assign t2_c = d2 - difs2;

  always_ff @(posedge clk) begin
    if (en) begin
      found3 <= (d2 > difs2) && (d2 < sums2);
      kneg3  <= kp_c[KW-1];
      kmag3  <= kp_c[KW-1] ? km_c[KMW-1:0] : kp_c[KMW-1:0];
      t1_3   <= t1_c[2*W-1:0];
      t2_3   <= t2_c[2*W-1:0];
      den3   <= {d2[2*W-1:0], 1'b0};
    end
  end

  logic [4*W-1:0] prod_p;

  cpi_mul #(.AW(2*W), .BW(2*W)) u_mul_p (.clk, .en, .a(t1_3), .b(t2_3), .p(prod_p));

  // square-root chain
  logic [SQN-1:0]   rem_s  [SQN+1];
  logic [SQN-1:0]   root_s [SQN+1];
  logic [2*SQN-1:0] rad_s  [SQN+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = prod_p;

  for (genvar c = 0; c < SQN; c++) begin : g_sqrt
    cpi_sqrt_cell #(.RW(SQN)) u_cell (
      .clk, .en,
      .rem_in(rem_s[c]), .root_in(root_s[c]), .rad_in(rad_s[c]),
      .rem_out(rem_s[c+1]), .root_out(root_s[c+1]), .rad_out(rad_s[c+1])
    );
  end

  // side data
  logic [MW1-1:0] dxm_s, dym_s;
  logic [KMW-1:0] kmag_s;
  logic           dxn_m, dyn_m, kneg_m;

  cpi_delay #(.DW(2*MW1), .N(T_S)) u_dly_mag (
    .clk, .en, .d({dxm1, dym1}), .q({dxm_s, dym_s}));
  cpi_delay #(.DW(KMW), .N(T_S - T_R3)) u_dly_k (
    .clk, .en, .d(kmag3), .q(kmag_s));
  cpi_delay #(.DW(2), .N(T_M3)) u_dly_dsgn (
    .clk, .en, .d({dxn1, dyn1}), .q({dxn_m, dyn_m}));
  cpi_delay #(.DW(1), .N(T_M3 - T_R3)) u_dly_ksgn (
    .clk, .en, .d(kneg3), .q(kneg_m));

  // cross products
  logic [PRW-1:0] pr_a, pr_b, pr_c, pr_e;

  cpi_mul #(.AW(KMW), .BW(MW1)) u_mul_a (.clk, .en, .a(kmag_s), .b(dxm_s), .p(pr_a));
  cpi_mul #(.AW(KMW), .BW(MW1)) u_mul_b (.clk, .en, .a(kmag_s), .b(dym_s), .p(pr_b));
  cpi_mul #(.AW(KMW), .BW(MW1)) u_mul_c (.clk, .en, .a(KMW'(root_s[SQN])), .b(dxm_s),
                                         .p(pr_c));
  cpi_mul #(.AW(KMW), .BW(MW1)) u_mul_e (.clk, .en, .a(KMW'(root_s[SQN])), .b(dym_s),
                                         .p(pr_e));

  logic signed [NW-1:0] sa4, sb4, sc4, se4;
  logic signed [NW-1:0] n5 [LANES];
  logic [NMW-1:0]       nmag6 [LANES];
  logic [LANES-1:0]     nsg6;

  always_ff @(posedge clk) begin
    if (en) begin
      sa4 <= (dxn_m ^ kneg_m) ? -NW'(pr_a) : NW'(pr_a);
      sb4 <= (dyn_m ^ kneg_m) ? -NW'(pr_b) : NW'(pr_b);
      sc4 <= dxn_m ? -NW'(pr_c) : NW'(pr_c);
      se4 <= dyn_m ? -NW'(pr_e) : NW'(pr_e);
      n5[LANE_FX] <= sa4 + se4;
      n5[LANE_FY] <= sb4 - sc4;
      n5[LANE_SX] <= sa4 - se4;
      n5[LANE_SY] <= sb4 + sc4;
      for (int l = 0; l < LANES; l++) begin
        nsg6[l]  <= n5[l][NW-1];
        nmag6[l] <= n5[l][NW-1] ? NMW'(-n5[l]) : NMW'(n5[l]);
      end
    end
  end

  // divider chain
  logic [DNW-1:0]                 den_d [QW+1];
  logic [LANES-1:0][DNW-1:0]      rem_d [QW+1];
  logic [LANES-1:0][QW-1:0]       nq_d  [QW+1];

  cpi_delay #(.DW(DNW), .N(T_R6 - T_R3)) u_dly_den (
    .clk, .en, .d(den3), .q(den_d[0]));

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_d[0][l] = nmag6[l][QW +: DNW];
      nq_d[0][l]  = nmag6[l][QW-1:0];
    end
  end

  for (genvar c = 0; c < QW; c++) begin : g_div
    cpi_div_cell #(.DNW(DNW), .QW(QW)) u_cell (
      .clk, .en,
      .den_in(den_d[c]), .rem_in(rem_d[c]), .nq_in(nq_d[c]),
      .den_out(den_d[c+1]), .rem_out(rem_d[c+1]), .nq_out(nq_d[c+1])
    );
  end

  logic                found_q;
  logic signed [W-1:0] ax_q, ay_q;
  logic [LANES-1:0]    nsg_q;
  logic [T_Q-1:0]      vpipe;
  logic                vq;

  cpi_delay #(.DW(1), .N(T_Q - T_R3)) u_dly_found (
    .clk, .en, .d(found3), .q(found_q));
  cpi_delay #(.DW(2*W), .N(T_Q)) u_dly_base (
    .clk, .en, .d({ax1, ay1}), .q({ax_q, ay_q}));
  cpi_delay #(.DW(LANES), .N(QW)) u_dly_nsg (
    .clk, .en, .d(nsg6), .q(nsg_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[T_Q-2:0], v1};
    end
  end

  assign vq = vpipe[T_Q-1];

  // rounding, placement, saturation
  logic [W-1:0] res_c [LANES];

  always_comb begin
    logic              rnd;
    logic [QW:0]       mag;
    logic signed [VW-1:0] base;
    logic signed [VW-1:0] v;
    for (int l = 0; l < LANES; l++) begin
      rnd  = {rem_d[QW][l], 1'b0} >= {1'b0, den_d[QW]};
      mag  = {1'b0, nq_d[QW][l]} + (QW+1)'(rnd);
      base = (l == LANE_FX || l == LANE_SX) ? VW'(ax_q) : VW'(ay_q);
      v    = nsg_q[l] ? base - VW'(mag) : base + VW'(mag);
      if (!found_q) begin
        res_c[l] = '0;
      end else if (v[VW-1:W-1] == '0 || v[VW-1:W-1] == '1) begin
        res_c[l] = v[W-1:0];
      end else if (v[VW-1]) begin
        res_c[l] = {1'b1, {(W-1){1'b0}}};
      end else begin
        res_c[l] = {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  // output register and skid
  logic         out_valid;
  logic         out_found, skid_found;
  logic [W-1:0] out_c  [LANES];
  logic [W-1:0] skid_c [LANES];
  logic         take;
  logic         arrive;

  assign take   = out_valid && points.ready;
  assign arrive = en && vq;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (arrive && (!out_valid || take)) begin
        out_valid <= 1'b1;
      end else if (arrive) begin
        skid_valid <= 1'b1;
      end else if (take && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (take) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (arrive && (!out_valid || take)) begin
      out_found <= found_q;
      out_c     <= res_c;
    end else if (arrive) begin
      skid_found <= found_q;
      skid_c     <= res_c;
    end else if (take && skid_valid) begin
      out_found <= skid_found;
      out_c     <= skid_c;
    end else begin
      out_found <= out_found;
    end
  end

  assign points.valid    = out_valid;
  assign points.found    = out_found;
  assign points.first_x  = out_c[LANE_FX];
  assign points.first_y  = out_c[LANE_FY];
  assign points.second_x = out_c[LANE_SX];
  assign points.second_y = out_c[LANE_SY];

endmodule

// ===== sv/cpi_checker.sv =====
// cpi_port_checker: port-level assertions for circle_pair_intersection_top, with its bind.
// Depends on circle_pair_intersection_top being compiled first.
module cpi_port_checker #(
  parameter int CW = 32
) (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic          found,
  input logic [CW-1:0] first_x,
  input logic [CW-1:0] first_y,
  input logic [CW-1:0] second_x,
  input logic [CW-1:0] second_y
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item present after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result item dropped");

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> first_x == '0 && first_y == '0 &&
                           second_x == '0 && second_y == '0)
    else $error("coordinates not cleared when no crossing");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready && out_valid && !out_ready |=> !in_ready)
    else $error("input reopened while both result slots full");

endmodule

bind circle_pair_intersection_top cpi_port_checker #(.CW(COORD_WIDTH)) u_cpi_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(circles.ready),
  .out_valid(points.valid),
  .out_ready(points.ready),
  .found(points.found),
  .first_x(points.first_x),
  .first_y(points.first_y),
  .second_x(points.second_x),
  .second_y(points.second_y)
);

// ===== test/cpi_checker.sv =====
// cpi_checker: watches both channels of the circle pair block, predicts each
// result item with exact wide integer arithmetic and compares it field by field.
// Depends on cpi_circle_if and cpi_point_if.
`timescale 1ns / 100ps

module cpi_checker (
  input  logic  clk,
  input  logic  rst,
  cpi_circle_if circles,
  cpi_point_if  points,
  output int    fails,
  output int    pending
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic               found;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
  } crossing_t;

  crossing_t crossings_due[$];

  function automatic wide_t floor_sqrt(wide_t n);
    wide_t r;
    wide_t t;
    r = 0;
    for (int i = 126; i >= 0; i--) begin
      t = r | (wide_t'(1) <<< i);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] place_coord(logic signed [63:0] base, wide_t num,
                                                    wide_t den);
    wide_t mag;
    wide_t q;
    wide_t rem;
    logic signed [63:0] v;
    mag = (num < 0) ? -num : num;
    q = mag / den;
    rem = mag % den;
    if (rem + rem >= den) q = q + 1;
    if (q > (wide_t'(1) <<< 60)) q = wide_t'(1) <<< 60;
    v = (num < 0) ? base - q[63:0] : base + q[63:0];
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic crossing_t cross_circles(logic signed [31:0] ax, logic signed [31:0] ay,
                                              logic [30:0] ra, logic signed [31:0] bx,
                                              logic signed [31:0] by, logic [30:0] rb);
    crossing_t c;
    wide_t dx, dy, dd, sum2, dif2, k, s, den, wa, wb;
    dx = wide_t'(bx) - wide_t'(ay - ay + ax);
    dy = wide_t'(by) - wide_t'(ay);
    wa = wide_t'({1'b0, ra});
    wb = wide_t'({1'b0, rb});
    dd = dx * dx + dy * dy;
    sum2 = (wa + wb) * (wa + wb);
    dif2 = (wa - wb) * (wa - wb);
    c = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    if (dd > dif2 && dd < sum2) begin
      k = wa * wa - wb * wb + dd;
      s = floor_sqrt((sum2 - dd) * (dd - dif2));
      den = dd + dd;
      c.found = 1'b1;
      c.first_x = place_coord(ax, dx * k + dy * s, den);
      c.first_y = place_coord(ay, dy * k - dx * s, den);
      c.second_x = place_coord(ax, dx * k - dy * s, den);
      c.second_y = place_coord(ay, dy * k + dx * s, den);
    end
    return c;
  endfunction

  assign pending = crossings_due.size();

  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      fails <= 0;
    end else begin
      if (circles.valid && circles.ready)
        crossings_due.push_back(cross_circles(circles.center_a_x, circles.center_a_y,
          circles.radius_a, circles.center_b_x, circles.center_b_y, circles.radius_b));
      if (points.valid && points.ready) begin
        if (crossings_due.size() == 0) begin
          $error("result item with nothing expected");
          fails <= fails + 1;
        end else begin
          want = crossings_due.pop_front();
          if (points.found !== want.found || points.first_x !== want.first_x ||
              points.first_y !== want.first_y || points.second_x !== want.second_x ||
              points.second_y !== want.second_y) begin
            fails <= fails + 1;
            if (points.found !== want.found)
              $error("found: expected %0d, got %0d", want.found, points.found);
            if (points.first_x !== want.first_x)
              $error("first_x: expected %0d, got %0d", want.first_x, points.first_x);
            if (points.first_y !== want.first_y)
              $error("first_y: expected %0d, got %0d", want.first_y, points.first_y);
            if (points.second_x !== want.second_x)
              $error("second_x: expected %0d, got %0d", want.second_x, points.second_x);
            if (points.second_y !== want.second_y)
              $error("second_y: expected %0d, got %0d", want.second_y, points.second_y);
          end
        end
      end
    end
  end

endmodule

// ===== test/circle_pair_intersection_top_tb.sv =====
// circle_pair_intersection_top_tb: drives circle pairs and output stalls into the block
// and gives the verdict. Depends on cpi_circle_if, cpi_point_if, cpi_checker and the block.
`timescale 1ns / 100ps

module circle_pair_intersection_top_tb;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fails;
  int   pending;
  int   idle_cycles = 0;
  int   stall_left = 0;
  logic stall_on = 1'b0;

  cpi_circle_if #(32) circles ();
  cpi_point_if  #(32) points ();

  circle_pair_intersection_top #(.COORD_WIDTH(32)) uut (
    .clk(clk), .rst(rst), .circles(circles), .points(points)
  );

  cpi_checker chk (
    .clk(clk), .rst(rst), .circles(circles), .points(points),
    .fails(fails), .pending(pending)
  );

  always #10 clk = ~clk;

  initial begin
    circles.valid = 1'b0;
    circles.center_a_x = '0;
    circles.center_a_y = '0;
    circles.radius_a = '0;
    circles.center_b_x = '0;
    circles.center_b_y = '0;
    circles.radius_b = '0;
    points.ready = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // output stalls in runs: long ready stretches, short stalls, a few long ones
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left == 0) begin
        stall_on = ($urandom_range(0, 99) < 40);
        if (!stall_on) stall_left = $urandom_range(1, 40);
        else if ($urandom_range(0, 9) < 8) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(20, 60);
      end
      stall_left--;
      points.ready = !stall_on;
    end
  end

  always @(posedge clk) begin
    if (rst || (circles.valid && circles.ready) || (points.valid && points.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pair(logic signed [31:0] ax, logic signed [31:0] ay, logic [30:0] ra,
                           logic signed [31:0] bx, logic signed [31:0] by, logic [30:0] rb);
    int gap;
    circles.center_a_x = ax;
    circles.center_a_y = ay;
    circles.radius_a = ra;
    circles.center_b_x = bx;
    circles.center_b_y = by;
    circles.radius_b = rb;
    circles.valid = 1'b1;
    while (!circles.ready) @(negedge clk);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      circles.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_random();
    int unsigned sh, ra, rb, span, r;
    logic signed [63:0] ax, ay, dx, dy;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_pair($urandom, $urandom, 31'($urandom), $urandom, $urandom, 31'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: sh = 8;
        1: sh = 16;
        2: sh = 24;
        default: sh = 31;
      endcase
      ra = 32'($urandom & ((64'd1 << sh) - 1));
      rb = 32'($urandom & ((64'd1 << sh) - 1));
      span = ra + rb;
      dx = $urandom_range(0, span);
      dy = $urandom_range(0, span);
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      if (r < 30) begin
        ax = $signed($urandom);
        ay = $signed($urandom);
      end else begin
        ax = $signed($urandom) >>> $urandom_range(4, 24);
        ay = $signed($urandom) >>> $urandom_range(4, 24);
      end
      send_pair(ax[31:0], ay[31:0], ra[30:0], ax[31:0] + dx[31:0], ay[31:0] + dy[31:0],
                rb[30:0]);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pair(0, 0, 31'd1280, 32'sd1280, 0, 31'd1280);
    send_pair(0, 0, 31'd1000, 32'sd3000, 32'sd4000, 31'd4500);
    send_pair(0, 0, 31'd768, 32'sd1536, 0, 31'd768);          // outer tangent
    send_pair(0, 0, 31'd2560, 32'sd1280, 0, 31'd1280);        // inner tangent
    send_pair(32'sd500, -32'sd500, 31'd900, 32'sd500, -32'sd500, 31'd400); // concentric
    send_pair(32'sd500, -32'sd500, 31'd900, 32'sd500, -32'sd500, 31'd900);
    send_pair(0, 0, 31'd100, 32'sd10000, 0, 31'd100);         // disjoint
    send_pair(0, 0, 31'd5000, 32'sd10, 32'sd10, 31'd100);     // inside
    send_pair(0, 0, 31'd0, 0, 0, 31'd0);
    send_pair(0, 0, 31'd0, 32'sd1, 0, 31'd1);
    send_pair(0, 0, 31'd1, 32'sd1, 0, 31'd1);
    send_pair(32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 32'h7fffffff, 32'h7ffff000,
              31'h7fffffff);
    send_pair(32'h80000000, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h80001000,
              31'h7fffffff);
    send_pair(32'h80000000, 32'h80000000, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              31'h7fffffff);
    send_pair(32'h80000000, 0, 31'h7fffffff, 32'h7fffffff, 0, 31'h7fffffff);
    send_pair(32'h7fffffff, 32'h80000000, 31'h7fffffff, 32'h80000000, 32'h7fffffff,
              31'h7fffffff);
    send_pair(32'hffffffff, 32'hffffffff, 31'h7fffffff, 0, 0, 31'h7ffffffe);
    send_pair(-32'sd3, 32'sd7, 31'd5, 32'sd4, -32'sd2, 31'd9);

    for (int i = 0; i < 400; i++) begin
      if (i == 200) begin
        circles.valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      send_random();
    end

    circles.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
